// ----- hdl/sifn_pkg.sv -----
// ----------------------------------------------------------------------------
// sifn_pkg
// Shared types, codes and helpers of the integrate-and-fire soma.
// ----------------------------------------------------------------------------
package sifn_pkg;

   localparam int KIND_W    = 2;
   localparam int NEURON_W  = 10;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int FRAC_BITS = 16;

   // 1.0 in the fixed-point format
   localparam logic [DATA_W-1:0] THRESH_RESET = DATA_W'(1) << FRAC_BITS;

   typedef enum logic [KIND_W-1:0] {
      KIND_STEP   = 2'd0,
      KIND_THRESH = 2'd1,
      KIND_BIAS   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED = 2'd0,
      ST_FIRED   = 2'd1,
      ST_WRITTEN = 2'd2
   } status_type;

   typedef struct packed {
      logic                     inclusive;
      logic                     has_current;
      logic signed [DATA_W-1:0] current;
      logic signed [DATA_W-1:0] potential;
      logic signed [DATA_W-1:0] bias;
      logic signed [DATA_W-1:0] threshold;
   } core_in_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] potential;
   } core_out_type;

   // clamp a 33-bit exact sum to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/subtractive_if_neuron_soma.sv -----
// ----------------------------------------------------------------------------
// subtractive_if_neuron_soma
// Integrate-and-fire soma without leak, subtractive reset, per-neuron stores.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  req     | req_valid/ready, kind, neuron, has_current,    | in
//          | current, attr_value                            |
//  rsp     | rsp_valid/ready, status, potential_out         | out
//  csr     | csr_valid/ready, inclusive_mode                | in
//
//  one beat per cycle while rsp is not stalled; a result passes the store read,
//  then the update stage and result register, with last-write forwarding
//  after reset every store address is swept with req_ready low
//  a stalled rsp holds the item in the update stage and stops req
//  kind 3 beats are taken and give no result
// ----------------------------------------------------------------------------
module subtractive_if_neuron_soma
   import sifn_pkg::*;
#(
   parameter int NEURONS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [NEURON_W-1:0]      req_neuron,
   input  logic                     req_has_current,
   input  logic signed [DATA_W-1:0] req_current,
   input  logic signed [DATA_W-1:0] req_attr_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_potential_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_inclusive_mode
);

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);

   typedef struct packed {
      logic              valid;
      logic [AW-1:0]     addr;
      logic [DATA_W-1:0] data;
   } fwd_type;

   // mode register
   logic incl_ff, incl_in;

   // clearing sweep
   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;

   // update stage
   logic              s1_valid_ff, s1_valid_in;
   kind_type          s1_kind_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              s1_inrange_ff;
   logic              s1_has_cur_ff;
   logic [DATA_W-1:0] s1_cur_ff;
   logic [DATA_W-1:0] s1_attr_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_pot_ff, rsp_pot_in;

   // last writes to each store
   fwd_type fwd_pot_ff, fwd_pot_in;
   fwd_type fwd_thr_ff, fwd_thr_in;
   fwd_type fwd_bias_ff, fwd_bias_in;

   logic              req_fire, s1_adv, s1_commit;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] pot_rd, thr_rd, bias_rd;
   logic [DATA_W-1:0] pot_cur, thr_cur, bias_cur;
   logic              pot_we, thr_we, bias_we;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] pot_wd, thr_wd, bias_wd;
   core_in_type       core_in;
   core_out_type      core_out;

   assign csr_ready = 1'b1;
   assign incl_in   = csr_valid ? csr_inclusive_mode : incl_ff;

   // handshakes
   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign s1_commit = s1_valid_ff && s1_adv;
   assign req_ready = !clear_ff && (!s1_valid_ff || s1_adv);
   assign req_fire  = req_valid && req_ready;
   assign rd_addr   = AW'(req_neuron);

   assign s1_valid_in = req_fire ? 1'b1 : (s1_commit ? 1'b0 : s1_valid_ff);

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         if (clear_cnt_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end else begin
            clear_cnt_in = clear_cnt_ff + AW'(1);
         end
      end
   end

   // forwarding covers the write made in the same cycle as the read
   assign pot_cur  = (fwd_pot_ff.valid && fwd_pot_ff.addr == s1_addr_ff) ?
                     fwd_pot_ff.data : pot_rd;
   assign thr_cur  = (fwd_thr_ff.valid && fwd_thr_ff.addr == s1_addr_ff) ?
                     fwd_thr_ff.data : thr_rd;
   assign bias_cur = (fwd_bias_ff.valid && fwd_bias_ff.addr == s1_addr_ff) ?
                     fwd_bias_ff.data : bias_rd;

   always_comb begin
      core_in.inclusive   = incl_ff;
      core_in.has_current = s1_has_cur_ff;
      core_in.current     = s1_cur_ff;
      core_in.potential   = pot_cur;
      core_in.bias        = bias_cur;
      core_in.threshold   = thr_cur;
   end

   sifn_core u_core (
      .core_in  (core_in),
      .core_out (core_out)
   );

   // store writes: sweep first, then committed items
   always_comb begin
      logic item_we;
      item_we = s1_commit && s1_inrange_ff;
      pot_we  = clear_ff || (item_we && s1_kind_ff == KIND_STEP);
      thr_we  = clear_ff || (item_we && s1_kind_ff == KIND_THRESH);
      bias_we = clear_ff || (item_we && s1_kind_ff == KIND_BIAS);
      wr_addr = clear_ff ? clear_cnt_ff : s1_addr_ff;
      pot_wd  = clear_ff ? '0 : core_out.potential;
      thr_wd  = clear_ff ? THRESH_RESET : s1_attr_ff;
      bias_wd = clear_ff ? '0 : s1_attr_ff;
   end

   always_comb begin
      fwd_pot_in  = fwd_pot_ff;
      fwd_thr_in  = fwd_thr_ff;
      fwd_bias_in = fwd_bias_ff;
      if (!clear_ff) begin
         if (pot_we) begin
            fwd_pot_in = '{valid: 1'b1, addr: wr_addr, data: pot_wd};
         end
         if (thr_we) begin
            fwd_thr_in = '{valid: 1'b1, addr: wr_addr, data: thr_wd};
         end
         if (bias_we) begin
            fwd_bias_in = '{valid: 1'b1, addr: wr_addr, data: bias_wd};
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pot_in    = rsp_pot_ff;
      if (s1_commit) begin
         rsp_valid_in = (s1_kind_ff != KIND_NONE);
         if (!s1_inrange_ff) begin
            rsp_status_in = (s1_kind_ff == KIND_STEP) ? ST_UPDATED : ST_WRITTEN;
            rsp_pot_in    = '0;
         end else if (s1_kind_ff == KIND_STEP) begin
            rsp_status_in = core_out.status;
            rsp_pot_in    = core_out.potential;
         end else begin
            rsp_status_in = ST_WRITTEN;
            rsp_pot_in    = pot_cur;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   sifn_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_pot_ram (
      .clock   (clock),
      .wr_en   (pot_we),
      .wr_addr (wr_addr),
      .wr_data (pot_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (pot_rd)
   );

   sifn_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_thr_ram (
      .clock   (clock),
      .wr_en   (thr_we),
      .wr_addr (wr_addr),
      .wr_data (thr_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (thr_rd)
   );

   sifn_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (wr_addr),
      .wr_data (bias_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (bias_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         incl_ff           <= 1'b0;
         clear_ff          <= 1'b1;
         clear_cnt_ff      <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         fwd_pot_ff.valid  <= 1'b0;
         fwd_thr_ff.valid  <= 1'b0;
         fwd_bias_ff.valid <= 1'b0;
      end else begin
         incl_ff           <= incl_in;
         clear_ff          <= clear_in;
         clear_cnt_ff      <= clear_cnt_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         fwd_pot_ff.valid  <= fwd_pot_in.valid;
         fwd_thr_ff.valid  <= fwd_thr_in.valid;
         fwd_bias_ff.valid <= fwd_bias_in.valid;
      end
      fwd_pot_ff.addr  <= fwd_pot_in.addr;
      fwd_pot_ff.data  <= fwd_pot_in.data;
      fwd_thr_ff.addr  <= fwd_thr_in.addr;
      fwd_thr_ff.data  <= fwd_thr_in.data;
      fwd_bias_ff.addr <= fwd_bias_in.addr;
      fwd_bias_ff.data <= fwd_bias_in.data;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff    <= kind_type'(req_kind);
         s1_addr_ff    <= rd_addr;
         s1_inrange_ff <= (32'(req_neuron) < 32'(NEURONS));
         s1_has_cur_ff <= req_has_current;
         s1_cur_ff     <= req_current;
         s1_attr_ff    <= req_attr_value;
      end
      rsp_status_ff    <= rsp_status_in;
      rsp_pot_ff       <= rsp_pot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_potential_out = rsp_pot_ff;

endmodule

// ----- hdl/sifn_ram.sv -----
// ----------------------------------------------------------------------------
// sifn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sifn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sifn_core.sv -----
// ----------------------------------------------------------------------------
// sifn_core
// Timestep update: integrate current and bias, threshold test, subtractive reset.
// ----------------------------------------------------------------------------
module sifn_core
   import sifn_pkg::*;
(
   input  core_in_type  core_in,
   output core_out_type core_out
);

   logic signed [DATA_W-1:0] after_cur;
   logic signed [DATA_W-1:0] after_bias;
   logic signed [DATA_W-1:0] after_sub;
   logic signed [DATA_W-1:0] thresh;
   logic [DATA_W:0]          sum_cur;
   logic [DATA_W:0]          sum_bias;
   logic [DATA_W:0]          diff;
   logic                     fire;

   always_comb begin
      thresh  = core_in.threshold;
      sum_cur = {core_in.potential[DATA_W-1], core_in.potential}
              + {core_in.current[DATA_W-1], core_in.current};
      after_cur = core_in.has_current ? sat33(sum_cur) : core_in.potential;

      sum_bias   = {after_cur[DATA_W-1], after_cur} + {core_in.bias[DATA_W-1], core_in.bias};
      after_bias = sat33(sum_bias);

      fire = core_in.inclusive ? (after_bias >= thresh) : (after_bias > thresh);

      diff      = {after_bias[DATA_W-1], after_bias} - {thresh[DATA_W-1], thresh};
      after_sub = sat33(diff);

      core_out.status    = fire ? ST_FIRED : ST_UPDATED;
      core_out.potential = fire ? after_sub : after_bias;
   end

endmodule

// ----- hdl/sifn_checker.sv -----
// ----------------------------------------------------------------------------
// sifn_checker
// Port-level checks of the soma, bound to the top level.
// ----------------------------------------------------------------------------
module sifn_checker
   import sifn_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic signed [DATA_W-1:0] rsp_potential_out
);

   // a stalled result beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_potential_out))
      else $error("rsp payload changed while stalled");

   // store sweep blocks requests right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high during store sweep");

   // a fresh result traces back to a req beat through the update stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp beat without matching req beat");

endmodule

bind subtractive_if_neuron_soma sifn_checker u_sifn_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_potential_out (rsp_potential_out)
);
